### hdl/imr_pkg.sv
// Shared types and constants for the ICMP reply matcher.
package imr_pkg;

	localparam int WORD_BYTES     = 4;
	localparam int ICMP_HDR_BYTES = 8;
	localparam int SRC_FIRST_POS  = 12;
	localparam int SRC_LAST_POS   = 15;

	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_IDENT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 1'b1;

	// Decoupling queue between classifier and capture
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [7:0] pkt_byte;
		logic       pkt_last;
	} pkt_in_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] source_addr;
		logic        reply_kind;
	} match_out_t;

	// Which ident/sequence byte a packet byte carries
	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_ID_HI,
		CAP_ID_LO,
		CAP_SQ_HI,
		CAP_SQ_LO
	} cap_sel_t;

	// Classified byte handed from front to back
	typedef struct packed {
		logic [7:0] pkt_byte;
		logic       last;
		logic       first;
		logic       src_en;
		logic [1:0] src_idx;
		cap_sel_t   cap;
		logic       len_ok;
		logic       kind_te;
	} q_entry_t;

endpackage

### hdl/imr_front.sv
// Byte classifier: tracks packet position and header fields, tags each byte.
module imr_front #(
	parameter int MAX_PACKET_BYTES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  imr_pkg::pkt_in_t  in_data,
	output logic              q_push,
	output imr_pkg::q_entry_t q_entry,
	input  logic              q_full
);

	localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CW = PW + 2;

	logic [PW-1:0] pos_q;
	logic [5:0]    hlen_q;
	logic [5:0]    inner_q;
	logic [7:0]    type_q;

	logic          accept;
	logic          take;
	logic [CW-1:0] pos_w;
	logic [5:0]    nib_len;
	logic [5:0]    hlen_c;
	logic [5:0]    inner_c;
	logic [7:0]    type_c;
	logic          is_echo;
	logic          is_te;
	logic [CW-1:0] h_w;
	logic [CW-1:0] icmp_end;
	logic [CW-1:0] fld_base;
	logic [CW-1:0] fld_off;
	logic          fld_ok;
	logic [CW-1:0] size_w;
	logic          len_ok;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		take    = pos_q < PW'(MAX_PACKET_BYTES);
		pos_w   = CW'(pos_q);
		nib_len = 6'(in_data.pkt_byte[3:0] * imr_pkg::WORD_BYTES);
		hlen_c  = (pos_q == '0) ? nib_len : hlen_q;
		h_w     = CW'(hlen_c);
		type_c  = (take && pos_w == h_w) ? in_data.pkt_byte : type_q;
		is_echo = type_c == imr_pkg::TYPE_ECHO_REPLY;
		is_te   = type_c == imr_pkg::TYPE_TIME_EXCEEDED;

		icmp_end = h_w + CW'(imr_pkg::ICMP_HDR_BYTES);
		inner_c  = (take && is_te && pos_w == icmp_end) ? nib_len : inner_q;

		// Ident/sequence sit at offsets 4..7 of the outer or quoted ICMP header
		fld_base = is_echo ? h_w : icmp_end + CW'(inner_q);
		fld_ok   = take && (is_echo || (is_te && pos_w > icmp_end));
		fld_off  = pos_w - fld_base;

		q_entry.cap = imr_pkg::CAP_NONE;
		if (fld_ok) begin
			case (fld_off)
				CW'(4):  q_entry.cap = imr_pkg::CAP_ID_HI;
				CW'(5):  q_entry.cap = imr_pkg::CAP_ID_LO;
				CW'(6):  q_entry.cap = imr_pkg::CAP_SQ_HI;
				CW'(7):  q_entry.cap = imr_pkg::CAP_SQ_LO;
				default: q_entry.cap = imr_pkg::CAP_NONE;
			endcase
		end

		q_entry.pkt_byte = in_data.pkt_byte;
		q_entry.last     = in_data.pkt_last;
		q_entry.first    = pos_q == '0;
		q_entry.src_en   = take && pos_w >= CW'(imr_pkg::SRC_FIRST_POS)
			&& pos_w <= CW'(imr_pkg::SRC_LAST_POS);
		q_entry.src_idx  = pos_q[1:0];

		// Length check at end of packet, on bytes actually taken
		size_w = take ? pos_w + 1'b1 : pos_w;
		len_ok = 1'b0;
		if (size_w > h_w) begin
			if (is_echo)
				len_ok = size_w >= icmp_end;
			else if (is_te)
				len_ok = (size_w > icmp_end) && (size_w >= icmp_end + CW'(inner_c)
					+ CW'(imr_pkg::ICMP_HDR_BYTES));
		end
		q_entry.len_ok  = len_ok;
		q_entry.kind_te = is_te;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hlen_q  <= '0;
			inner_q <= '0;
			type_q  <= '0;
		end else if (accept) begin
			hlen_q  <= hlen_c;
			inner_q <= inner_c;
			type_q  <= type_c;
			if (in_data.pkt_last)
				pos_q <= '0;
			else if (take)
				pos_q <= pos_q + 1'b1;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_PACKET_BYTES))
		else $error("packet position beyond limit");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.pkt_last) |=> pos_q == '0)
		else $error("position not restarted after last byte");

endmodule

### hdl/imr_queue.sv
// Short FIFO of classified bytes between classifier and capture stage.
module imr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  imr_pkg::q_entry_t wr_entry,
	output logic              full,
	input  logic              pop,
	output imr_pkg::q_entry_t rd_entry,
	output logic              empty
);

	imr_pkg::q_entry_t mem_q [imr_pkg::QUEUE_DEPTH];

	logic [imr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [imr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [imr_pkg::QPTR_W:0]   count_q;

	assign full     = count_q == (imr_pkg::QPTR_W+1)'(imr_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

### hdl/imr_back.sv
// Capture stage: collects source, ident and sequence, builds the verdict.
module imr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [imr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  imr_pkg::q_entry_t             q_entry,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output imr_pkg::match_out_t           out_data
);

	logic [15:0] exp_id_q;
	logic [15:0] exp_sq_q;
	logic [31:0] src_q;
	logic [15:0] id_q;
	logic [15:0] sq_q;
	logic        out_valid_q;
	imr_pkg::match_out_t out_q;

	logic [31:0] src_n;
	logic [15:0] id_n;
	logic [15:0] sq_n;
	logic        ok;

	assign q_pop     = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		src_n = q_entry.first ? '0 : src_q;
		id_n  = q_entry.first ? '0 : id_q;
		sq_n  = q_entry.first ? '0 : sq_q;
		if (q_entry.src_en) begin
			case (q_entry.src_idx)
				2'd0:    src_n[31:24] = q_entry.pkt_byte;
				2'd1:    src_n[23:16] = q_entry.pkt_byte;
				2'd2:    src_n[15:8]  = q_entry.pkt_byte;
				default: src_n[7:0]   = q_entry.pkt_byte;
			endcase
		end
		case (q_entry.cap)
			imr_pkg::CAP_ID_HI: id_n[15:8] = q_entry.pkt_byte;
			imr_pkg::CAP_ID_LO: id_n[7:0]  = q_entry.pkt_byte;
			imr_pkg::CAP_SQ_HI: sq_n[15:8] = q_entry.pkt_byte;
			imr_pkg::CAP_SQ_LO: sq_n[7:0]  = q_entry.pkt_byte;
			default: ;
		endcase
		ok = q_entry.len_ok && id_n == exp_id_q && sq_n == exp_sq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= '0;
			exp_sq_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				imr_pkg::CFG_EXPECTED_IDENT:    exp_id_q <= cfg_data;
				imr_pkg::CFG_EXPECTED_SEQUENCE: exp_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			src_q <= src_n;
			id_q  <= id_n;
			sq_q  <= sq_n;
			if (q_entry.last) begin
				out_q.accepted    <= ok;
				out_q.source_addr <= src_n;
				out_q.reply_kind  <= ok && q_entry.kind_te;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop && q_entry.last)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	a_kind_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.reply_kind) |-> out_q.accepted)
		else $error("reply kind set on rejected packet");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !(out_valid_q && out_stall))
		else $error("pop while result held");

endmodule

### hdl/icmp_reply_matcher.sv
// Top level of the ICMP echo reply / time exceeded matcher.
//
// Input channel (in_valid/in_stall/in_data): one byte of a received IPv4
// packet per transaction, starting at the IP header, pkt_last on the final
// byte. Output channel (out_valid/out_stall/out_data): one transaction per
// packet with accepted, source_addr and reply_kind.
// Config port: cfg_we writes cfg_data into the register named by cfg_index
// (expected identifier, expected sequence); write only while idle.
// Throughput: one byte per cycle sustained while out_stall stays low. The
// front classifier tags each byte by position combinationally as it is
// written; the back stage captures fields and forms the verdict. A 4-entry
// FIFO separates them. The last byte is written into the FIFO, then popped
// into the result register, which raises out_valid.
// Stall: a held result keeps the back stage waiting; bytes keep entering
// until the 4-entry FIFO is full, then in_stall rises.
// Reset (arst_n low): packet position, header state, FIFO and output valid
// clear; expected identifier and sequence return to zero.
module icmp_reply_matcher #(
	parameter int MAX_PACKET_BYTES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  imr_pkg::pkt_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output imr_pkg::match_out_t           out_data,
	input  logic                          cfg_we,
	input  logic [imr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	// Classified-byte transactions between front and back
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	imr_pkg::q_entry_t q_wr_entry;
	imr_pkg::q_entry_t q_rd_entry;

	// Front: position tracking, header length/type decode, byte tagging
	imr_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_push   (q_push),
		.q_entry  (q_wr_entry),
		.q_full   (q_full)
	);

	// Decoupling FIFO
	imr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.empty    (q_empty)
	);

	// Back: field capture, compare against expected values, result register
	imr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_entry   (q_rd_entry),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
